### src/tcgw_pkg.sv
// Shared types, constants and the 5x7 glyph table for the text cursor glyph writer.
package tcgw_pkg;

  // Display geometry defaults and cell layout
  localparam int COLUMNS_DEF = 84;
  localparam int ROWS_DEF    = 6;
  localparam int CELL_W      = 6;
  localparam int GLYPH_W     = 5;
  localparam int GLYPH_CNT   = 96;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7F;

  typedef enum logic {
    KIND_TEXT   = 1'b0,
    KIND_CURSOR = 1'b1
  } kind_e;

  typedef enum logic {
    CMD_GLYPH = 1'b0,
    CMD_BLANK = 1'b1
  } cmd_op_e;

  // One queued cell write: glyph cell or blanked cell
  typedef struct packed {
    cmd_op_e    op;
    logic [6:0] glyph;
    logic [6:0] col;
    logic [2:0] row;
  } cmd_t;

  // Glyph columns for codes 0x20..0x7F, leftmost column in the top byte
  localparam logic [39:0] FONT_ROM [GLYPH_CNT] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
    40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
    40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
    40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
    40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
  };

  // Glyph lookup; indexes past the table read as blank
  function automatic logic [39:0] font_glyph(input logic [6:0] idx);
    logic [39:0] g;
    g = '0;
    if (idx < 7'(GLYPH_CNT)) begin
      g = FONT_ROM[idx];
    end
    return g;
  endfunction

endpackage

### src/tcgw_front.sv
// Front end: accepts text and cursor items, tracks the cursor, queues cell writes.
module tcgw_front #(
  parameter int COLUMNS = tcgw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcgw_pkg::ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             kind_i,
  input  logic [7:0]       char_code_i,
  input  logic [7:0]       new_col_i,
  input  logic [7:0]       new_row_i,
  output logic             push_o,
  output tcgw_pkg::cmd_t   cmd_o
);

  localparam logic [7:0] ColsW   = 8'(COLUMNS);
  localparam logic [7:0] ColLast = 8'(COLUMNS - 1);
  localparam logic [7:0] RowLast = 8'(ROWS - 1);
  localparam logic [3:0] RowsW   = 4'(ROWS);
  localparam logic [6:0] BsWrap  = 7'(COLUMNS - tcgw_pkg::CELL_W);
  localparam logic [7:0] CellW   = 8'(tcgw_pkg::CELL_W);

  logic [6:0] col_q, col_d;
  logic [2:0] row_q, row_d;

  logic [2:0] row_next, row_prev;
  logic       at_end;
  logic [6:0] start_col;
  logic [2:0] start_row;
  logic [2:0] start_row_next;
  logic [7:0] end_sum;

  // Row stepping with wrap
  always_comb begin
    row_next       = (({1'b0, row_q} + 4'd1) >= RowsW) ? 3'd0 : row_q + 3'd1;
    row_prev       = (row_q == 3'd0) ? 3'(ROWS - 1) : row_q - 3'd1;
    at_end         = ({1'b0, col_q} >= ColsW);
    start_col      = at_end ? 7'd0 : col_q;
    start_row      = at_end ? row_next : row_q;
    start_row_next = (({1'b0, start_row} + 4'd1) >= RowsW) ? 3'd0 : start_row + 3'd1;
    end_sum        = {1'b0, start_col} + CellW;
  end

  // Item decode and cursor update
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    push_o    = 1'b0;
    cmd_o.op  = tcgw_pkg::CMD_GLYPH;
    cmd_o.glyph = 7'(char_code_i - tcgw_pkg::CHAR_FIRST);
    cmd_o.col = start_col;
    cmd_o.row = start_row;
    if (accept_i) begin
      if (tcgw_pkg::kind_e'(kind_i) == tcgw_pkg::KIND_CURSOR) begin
        col_d = (new_col_i > ColLast) ? ColLast[6:0] : new_col_i[6:0];
        row_d = (new_row_i > RowLast) ? RowLast[2:0] : new_row_i[2:0];
      end else if (char_code_i == tcgw_pkg::CHAR_CR || char_code_i == tcgw_pkg::CHAR_LF) begin
        col_d = 7'd0;
        row_d = row_next;
      end else if (char_code_i == tcgw_pkg::CHAR_BS) begin
        if (col_q == 7'd0) begin
          col_d = BsWrap;
          row_d = row_prev;
        end else begin
          col_d = ({1'b0, col_q} >= CellW) ? col_q - 7'(tcgw_pkg::CELL_W) : 7'd0;
        end
        push_o    = 1'b1;
        cmd_o.op  = tcgw_pkg::CMD_BLANK;
        cmd_o.col = col_d;
        cmd_o.row = row_d;
      end else if (char_code_i >= tcgw_pkg::CHAR_FIRST) begin
        if (char_code_i <= tcgw_pkg::CHAR_LAST) begin
          push_o = 1'b1;
          // cell crosses the right edge: cursor ends on the next row
          if (end_sum > ColsW) begin
            col_d = 7'(end_sum - ColsW);
            row_d = start_row_next;
          end else begin
            col_d = end_sum[6:0];
            row_d = start_row;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 7'd0;
      row_q <= 3'd0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### src/tcgw_queue.sv
// Short command queue decoupling the front end from the column writer.
module tcgw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcgw_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tcgw_pkg::cmd_t cmd_o
);

  tcgw_pkg::cmd_t                      mem_q [tcgw_pkg::QUEUE_DEPTH];
  logic [tcgw_pkg::QPTR_W-1:0]         wr_ptr_q, rd_ptr_q;
  logic [tcgw_pkg::QCNT_W-1:0]         count_q;
  logic                                do_push, do_pop;

  assign full_o  = (count_q == tcgw_pkg::QCNT_W'(tcgw_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == tcgw_pkg::QPTR_W'(tcgw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == tcgw_pkg::QPTR_W'(tcgw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### src/tcgw_back.sv
// Back end: walks each queued cell one column per cycle, unless the receiver stalls, into the output register.
module tcgw_back #(
  parameter int COLUMNS = tcgw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcgw_pkg::ROWS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  tcgw_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [6:0]     out_column_o,
  output logic [2:0]     out_row_o,
  output logic [7:0]     out_pixels_o,
  output logic           out_last_o
);

  localparam logic [7:0] ColsW    = 8'(COLUMNS);
  localparam logic [3:0] RowsW    = 4'(ROWS);
  localparam logic [2:0] StepLast = 3'(tcgw_pkg::CELL_W - 1);

  logic           busy_q, busy_d;
  tcgw_pkg::cmd_t cur_q, cur_d;
  logic [2:0]     step_q, step_d;

  logic           vld_q, vld_d;
  logic [6:0]     ocol_q, ocol_d;
  logic [2:0]     orow_q, orow_d;
  logic [7:0]     opix_q, opix_d;
  logic           olast_q, olast_d;

  logic           advance, wrap, emit_ok, done;
  logic [6:0]     c;
  logic [2:0]     r;
  logic [39:0]    glyph;
  logic [7:0]     pix;

  assign advance = busy_q && (!vld_q || out_ready_i);

  // Current column position with wrap at the right edge for glyph cells
  always_comb begin
    wrap    = (cur_q.op == tcgw_pkg::CMD_GLYPH) && ({1'b0, cur_q.col} >= ColsW);
    c       = wrap ? 7'd0 : cur_q.col;
    r       = cur_q.row;
    if (wrap) begin
      r = (({1'b0, cur_q.row} + 4'd1) >= RowsW) ? 3'd0 : cur_q.row + 3'd1;
    end
    emit_ok = (cur_q.op == tcgw_pkg::CMD_GLYPH) || ({1'b0, c} < ColsW);
    done    = (step_q == StepLast) ||
              ((cur_q.op == tcgw_pkg::CMD_BLANK) && (({1'b0, c} + 8'd1) >= ColsW));
  end

  // Pixel byte for this column: glyph column, spacer or blank
  always_comb begin
    glyph = tcgw_pkg::font_glyph(cur_q.glyph);
    case (step_q)
      3'd0:    pix = glyph[39:32];
      3'd1:    pix = glyph[31:24];
      3'd2:    pix = glyph[23:16];
      3'd3:    pix = glyph[15:8];
      3'd4:    pix = glyph[7:0];
      default: pix = 8'h00;
    endcase
    if (cur_q.op == tcgw_pkg::CMD_BLANK) begin
      pix = 8'h00;
    end
  end

  // Cell sequencing; next command loads as the current one finishes
  always_comb begin
    q_pop_o = q_valid_i && (!busy_q || (advance && done));
    busy_d  = busy_q;
    cur_d   = cur_q;
    step_d  = step_q;
    if (q_pop_o) begin
      busy_d = 1'b1;
      cur_d  = q_cmd_i;
      step_d = 3'd0;
    end else if (advance) begin
      if (done) begin
        busy_d = 1'b0;
      end else begin
        cur_d.col = c + 7'd1;
        cur_d.row = r;
        step_d    = step_q + 3'd1;
      end
    end
  end

  // Output register
  always_comb begin
    vld_d   = vld_q;
    ocol_d  = ocol_q;
    orow_d  = orow_q;
    opix_d  = opix_q;
    olast_d = olast_q;
    if (out_ready_i) begin
      vld_d = 1'b0;
    end
    if (advance && emit_ok) begin
      vld_d   = 1'b1;
      ocol_d  = c;
      orow_d  = r;
      opix_d  = pix;
      olast_d = done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 3'd0;
      vld_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    ocol_q  <= ocol_d;
    orow_q  <= orow_d;
    opix_q  <= opix_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = vld_q;
  assign out_column_o = ocol_q;
  assign out_row_o    = orow_q;
  assign out_pixels_o = opix_q;
  assign out_last_o   = olast_q;

  // Writes always land on the display
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> ({1'b0, ocol_q} < ColsW))
    else $error("column write beyond right edge");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> ({1'b0, orow_q} < RowsW))
    else $error("row write beyond last byte row");

  // Step counter stays inside one cell
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= StepLast))
    else $error("cell step counter overran");

  // A finished cell never keeps the writer busy without a new load
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && done && !q_pop_o) |=> !busy_q)
    else $error("writer stayed busy after last column");

endmodule

### src/text_cursor_glyph_writer.sv
// Top level of the text cursor glyph writer: front end, command queue and column writer.
//
// Usage: items arrive on the s_axis stream. tuser selects the kind (0 = text byte,
// 1 = set cursor), tdata carries char_code, new_col and new_row. Each display column
// write leaves on the m_axis stream as column, row and pixel byte, with tlast on the
// final write caused by one item.
// A printable byte (0x20..0x7F) gives five glyph columns and one blank spacer, six
// transactions; backspace gives six blank columns; newline and set cursor update the
// cursor only and give nothing; other codes are ignored and give nothing.
// The column writer puts out one column per cycle unless the receiver stalls it. A
// two-entry command queue lets the input run ahead of the writer and take new items
// while earlier cells are still being written.
// Reset puts the cursor at column 0, row 0 and empties the queue and output.
// When the receiver stalls, the output register holds its transaction, the writer
// waits, the queue fills, and s_axis_tready drops once the queue is full.
module text_cursor_glyph_writer #(
  parameter int COLUMNS = tcgw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcgw_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // char_code[7:0], new_col[15:8], new_row[23:16]
  input  logic        s_axis_tuser,   // kind[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // column[6:0], row[9:7], pixels[17:10], zero[23:18]
  output logic        m_axis_tlast
);

  logic           accept;
  logic           push, full;
  tcgw_pkg::cmd_t push_cmd, q_cmd;
  logic           q_valid, q_pop;
  logic [6:0]     out_column;
  logic [2:0]     out_row;
  logic [7:0]     out_pixels;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tcgw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .kind_i     (s_axis_tuser),
    .char_code_i(s_axis_tdata[7:0]),
    .new_col_i  (s_axis_tdata[15:8]),
    .new_row_i  (s_axis_tdata[23:16]),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tcgw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (q_cmd)
  );

  tcgw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_column_o(out_column),
    .out_row_o   (out_row),
    .out_pixels_o(out_pixels),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_pixels, out_row, out_column};

endmodule
